// ===== rtl/string_intern_hash_table_top_defines.svh =====
// Assertion macros shared by the string interning store.
`ifndef STRING_INTERN_HASH_TABLE_TOP_DEFINES_SVH
`define STRING_INTERN_HASH_TABLE_TOP_DEFINES_SVH
// Assert that a condition implies another in the same cycle.
`define SIH_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Assert that a condition implies another in the next cycle.
`define SIH_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

// ===== rtl/sih_pkg.sv =====
// Types and constants shared by the string interning store.
`default_nettype none
package sih_pkg;
    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_LONG = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [7:0] GEN_LAST = 8'd255;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HASH, S_PROBE, S_SLOT, S_CMP, S_CMPW, S_COPY, S_COPYW,
        S_WSLOT, S_RESP, S_TAGCLR
    } sih_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic take_byte;
        logic clear_gen;
        logic clr_slot;
        logic start_probe;
        logic rd_slot;
        logic next_slot;
        logic cmp_start;
        logic cmp_rd;
        logic cmp_step;
        logic copy_start;
        logic copy_rd;
        logic copy_step;
        logic write_slot;
        logic set_found;
        logic set_long;
        logic set_full;
        logic drop;
        logic mult_step;
    } sih_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic overlong;
        logic slot_busy;
        logic probe_wrapped;
        logic cmp_done;
        logic cmp_equal;
        logic copy_done;
        logic fits;
        logic clr_done;
        logic gen_wrap;
    } sih_stat_t;
endpackage
`default_nettype wire

// ===== rtl/sih_ctrl.sv =====
// Controller state machine for the string interning store.
`default_nettype none
module sih_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic              last,
    input  wire logic              char_nz,
    output logic                   res_load,
    input  wire logic              res_pending,
    input  wire sih_pkg::sih_stat_t stat,
    output sih_pkg::sih_cmd_t      cmd
);
    import sih_pkg::*;

    sih_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            S_CLR, S_TAGCLR:
            begin
                cmd.clr_slot = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func)
                    begin
                        cmd.clear_gen = 1'b1;
                        cmd.drop = 1'b1;
                        if (stat.gen_wrap)
                            state_next = S_TAGCLR;
                    end
                    else if (last)
                    begin
                        if (stat.overlong)
                        begin
                            cmd.set_long = 1'b1;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.start_probe = 1'b1;
                            state_next = S_PROBE;
                        end
                    end
                    else if (char_nz)
                    begin
                        cmd.take_byte = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                cmd.mult_step = 1'b1;
                state_next = S_IDLE;
            end
            S_PROBE:
            begin
                cmd.rd_slot = 1'b1;
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                if (!stat.slot_busy)
                begin
                    if (stat.fits)
                    begin
                        cmd.copy_start = 1'b1;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        cmd.set_full = 1'b1;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cmd.cmp_start = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.cmp_rd = 1'b1;
                state_next = S_CMPW;
            end
            S_CMPW:
            begin
                if (!stat.cmp_equal)
                begin
                    if (stat.probe_wrapped)
                    begin
                        cmd.set_full = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.next_slot = 1'b1;
                        state_next = S_PROBE;
                    end
                end
                else if (stat.cmp_done)
                begin
                    cmd.set_found = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.cmp_step = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_COPY:
            begin
                cmd.copy_rd = 1'b1;
                state_next = S_COPYW;
            end
            S_COPYW:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_done)
                    state_next = S_WSLOT;
                else
                    state_next = S_COPY;
            end
            S_WSLOT:
            begin
                cmd.write_slot = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!res_pending)
                begin
                    res_load = 1'b1;
                    cmd.drop = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/sih_dp.sv =====
// Datapath of the string interning store: hash, buffer, table and arena.
`default_nettype none
module sih_dp #(
    parameter int TEXT_BYTES  = 4096,
    parameter int TABLE_SLOTS = 4096,
    parameter int STR_LEN_MAX = 255
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sih_pkg::sih_cmd_t  cmd,
    output sih_pkg::sih_stat_t      stat,
    input  wire logic [7:0]         char_byte,
    input  wire logic               cfg_we,
    input  wire logic [12:0]        cfg_wdata,
    output logic                    r_found,
    output logic [11:0]             r_offset,
    output logic [1:0]              r_status
);
    import sih_pkg::*;

    localparam int AW = $clog2(TEXT_BYTES);
    localparam int UW = AW + 1;
    localparam int SW = $clog2(TABLE_SLOTS);
    localparam int PW = (STR_LEN_MAX > 1) ? $clog2(STR_LEN_MAX) : 1;
    localparam int LW = $clog2(STR_LEN_MAX + 1);
    localparam int EW = UW;

    // Memories.
    logic [EW-1:0] slot_entry_mem [TABLE_SLOTS];
    logic [7:0]    slot_tag_mem   [TABLE_SLOTS];
    logic [7:0]    arena_mem      [TEXT_BYTES];
    logic [7:0]    pend_mem       [STR_LEN_MAX];

    logic [12:0]   text_limit_reg;
    logic [7:0]    gen_reg;
    logic [UW-1:0] used_reg;
    logic [LW-1:0] plen_reg;
    logic [31:0]   hash_reg;
    logic [31:0]   xor_reg;
    logic          long_reg;
    logic [SW:0]   clr_reg;
    logic [SW-1:0] slot_reg;
    logic [SW:0]   probes_reg;
    logic [EW-1:0] ent_q_reg;
    logic [7:0]    tag_q_reg;
    logic [EW-1:0] ent_reg;
    logic [LW-1:0] idx_reg;
    logic [7:0]    ar_q_reg;
    logic [7:0]    pd_q_reg;
    logic          arok_reg;
    logic          found_reg;
    logic [11:0]   off_reg;
    logic [1:0]    st_reg;

    logic [UW-1:0] limit_w;
    logic [UW-1:0] room_w;
    logic [UW:0]   cmp_addr_w;

    // Effective space left in the arena.
    always_comb
    begin
        limit_w = (text_limit_reg > 13'(TEXT_BYTES)) ? UW'(TEXT_BYTES) : UW'(text_limit_reg);
        room_w = (used_reg < limit_w) ? (limit_w - used_reg) : '0;
        cmp_addr_w = (UW + 1)'(ent_reg) - (UW + 1)'(1) + (UW + 1)'(idx_reg);
    end

    // Configuration, generation, hash and pending buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_limit_reg <= 13'd4096;
            gen_reg <= 8'd1;
            used_reg <= '0;
            plen_reg <= '0;
            hash_reg <= HASH_BASIS;
            long_reg <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                text_limit_reg <= cfg_wdata;
            if (cmd.clr_slot)
                clr_reg <= clr_reg + 1'b1;
            else
                clr_reg <= '0;
            if (cmd.clear_gen)
            begin
                used_reg <= '0;
                gen_reg <= (gen_reg == GEN_LAST) ? 8'd1 : gen_reg + 8'd1;
            end
            if (cmd.take_byte)
            begin
                if (plen_reg >= LW'(STR_LEN_MAX))
                    long_reg <= 1'b1;
                else
                    plen_reg <= plen_reg + 1'b1;
            end
            if (cmd.mult_step && !long_reg)
                hash_reg <= xor_reg * HASH_PRIME;
            if (cmd.mult_step && long_reg)
                hash_reg <= hash_reg;
            if (cmd.write_slot)
                used_reg <= used_reg + UW'(plen_reg) + 1'b1;
            if (cmd.drop)
            begin
                plen_reg <= '0;
                hash_reg <= HASH_BASIS;
                long_reg <= 1'b0;
            end
        end
    end

    // Byte staging: the xor is registered and the multiply runs next cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            xor_reg <= hash_reg ^ {24'd0, char_byte};
            if (plen_reg < LW'(STR_LEN_MAX))
                pend_mem[PW'(plen_reg)] <= char_byte;
        end
    end

    // Table memory: one write port and one read port, cleared by sweep, read registered.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_slot && !clr_reg[SW])
        begin
            slot_tag_mem[clr_reg[SW-1:0]] <= '0;
            slot_entry_mem[clr_reg[SW-1:0]] <= '0;
        end
        else if (cmd.write_slot)
        begin
            slot_tag_mem[slot_reg] <= gen_reg;
            slot_entry_mem[slot_reg] <= used_reg + 1'b1;
        end
        if (cmd.rd_slot)
        begin
            ent_q_reg <= slot_entry_mem[slot_reg];
            tag_q_reg <= slot_tag_mem[slot_reg];
        end
    end

    // Arena memory: copy writes and compare reads, registered.
    always_ff @(posedge clk)
    begin
        if (cmd.copy_step)
            arena_mem[AW'(used_reg + UW'(idx_reg))] <= (idx_reg == plen_reg) ? 8'd0 : pd_q_reg;
        if (cmd.cmp_rd)
        begin
            ar_q_reg <= arena_mem[AW'(cmp_addr_w)];
            arok_reg <= (cmp_addr_w < (UW + 1)'(TEXT_BYTES));
        end
        if (cmd.cmp_rd || cmd.copy_rd)
            pd_q_reg <= (idx_reg == plen_reg) ? 8'd0 : pend_mem[PW'(idx_reg)];
    end

    // Probe and walk control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            probes_reg <= '0;
            ent_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
            off_reg <= '0;
            st_reg <= ST_OK;
        end
        else
        begin
            if (cmd.start_probe)
            begin
                slot_reg <= hash_reg[SW-1:0];
                probes_reg <= '0;
            end
            if (cmd.next_slot)
            begin
                slot_reg <= slot_reg + 1'b1;
                probes_reg <= probes_reg + 1'b1;
            end
            if (cmd.cmp_start)
            begin
                ent_reg <= ent_q_reg;
                idx_reg <= '0;
            end
            if (cmd.copy_start)
                idx_reg <= '0;
            if (cmd.cmp_step || cmd.copy_step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
                off_reg <= 12'(ent_reg - 1'b1);
                st_reg <= ST_OK;
            end
            if (cmd.write_slot)
            begin
                found_reg <= 1'b0;
                off_reg <= 12'(used_reg);
                st_reg <= ST_OK;
            end
            if (cmd.set_long || cmd.set_full)
            begin
                found_reg <= 1'b0;
                off_reg <= '0;
                st_reg <= cmd.set_long ? ST_LONG : ST_FULL;
            end
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat.overlong = long_reg;
        stat.slot_busy = (tag_q_reg == gen_reg) && (ent_q_reg != '0);
        stat.probe_wrapped = (probes_reg == (SW + 1)'(TABLE_SLOTS - 1));
        stat.cmp_done = (idx_reg == plen_reg);
        stat.cmp_equal = arok_reg && (ar_q_reg == pd_q_reg);
        stat.copy_done = (idx_reg == plen_reg);
        stat.fits = ((UW + 1)'(plen_reg) + 1'b1) <= (UW + 1)'(room_w);
        stat.clr_done = clr_reg[SW];
        stat.gen_wrap = (gen_reg == GEN_LAST);
        r_found = found_reg;
        r_offset = off_reg;
        r_status = st_reg;
    end
endmodule
`default_nettype wire

// ===== rtl/string_intern_hash_table_top.sv =====
// Top level of the string interning store.
`default_nettype none
`include "string_intern_hash_table_top_defines.svh"
// String interning store. A byte item is hashed in two steps: the xor is
// registered when the byte is taken, then S_HASH does the FNV-1a multiply.
// A terminator probes table slots from the hash, each slot read registered,
// and on a busy slot compares the arena text byte by byte, each byte read
// registered, the closing NUL included. A new string, if it fits, is then
// appended byte by byte, NUL included, and its slot is written. No new item
// is accepted until the result is loaded into the output register. After
// reset, and after a clear that wraps the generation, a sweep zeroes every
// table slot while no item is accepted.
module string_intern_hash_table_top #(
    parameter int TEXT_BYTES  = 4096,
    parameter int TABLE_SLOTS = 4096,
    parameter int STR_LEN_MAX = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  char_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [11:0]      offset,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata
);
    import sih_pkg::*;

    sih_cmd_t  cmd;
    sih_stat_t stat;
    logic      res_load;
    logic      r_found;
    logic [11:0] r_offset;
    logic [1:0]  r_status;
    logic        out_valid_reg;
    logic        found_reg;
    logic [11:0] offset_reg;
    logic [1:0]  status_reg;

    sih_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .last(last), .char_nz(char_byte != 8'd0),
        .res_load(res_load), .res_pending(out_valid_reg && !out_ready),
        .stat(stat), .cmd(cmd)
    );

    sih_dp #(
        .TEXT_BYTES(TEXT_BYTES), .TABLE_SLOTS(TABLE_SLOTS),
        .STR_LEN_MAX(STR_LEN_MAX)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .char_byte(char_byte),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .r_found(r_found), .r_offset(r_offset), .r_status(r_status)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            found_reg <= r_found;
            offset_reg <= r_offset;
            status_reg <= r_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign found = found_reg;
    assign offset = offset_reg;
    assign status = status_reg;

    `SIH_ASSERT_IMPLY(a_err_no_found, clk, rst_n, out_valid && status != ST_OK, !found && offset == '0)
    `SIH_ASSERT_IMPLY(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.take_byte, cmd.start_probe, cmd.write_slot, cmd.clear_gen}))
    `SIH_ASSERT_NEXT(a_load_valid, clk, rst_n, res_load, out_valid)
endmodule
`default_nettype wire

// ===== dv/tb_string_intern_hash_table_top.sv =====
// Self-checking testbench for the string interning store.
`timescale 1ns / 1ps
`default_nettype none
module tb_string_intern_hash_table_top;
    import sih_pkg::*;

    localparam int TEXT_BYTES = 4096;
    localparam int TABLE_SLOTS = 4096;
    localparam int STR_LEN_MAX = 255;
    localparam logic FUNC_STRING = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;
    localparam int CYCLE_LIMIT = 3000000;
    // Idling modes.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic       func;
        logic [7:0] char_byte;
        logic       last;
    } sym_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] offset;
        logic [1:0]  status;
    } lookup_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic in_taken;
    logic func;
    logic [7:0] char_byte;
    logic last;
    logic out_valid;
    logic out_ready;
    logic found;
    logic [11:0] offset;
    logic [1:0] status;
    logic cfg_we;
    logic [12:0] cfg_wdata;

    string_intern_hash_table_top #(
        .TEXT_BYTES(TEXT_BYTES),
        .TABLE_SLOTS(TABLE_SLOTS),
        .STR_LEN_MAX(STR_LEN_MAX)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .char_byte(char_byte), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .offset(offset), .status(status),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Shadow of the store's state.
    logic [12:0] sh_entry [TABLE_SLOTS];
    logic [7:0]  sh_tag [TABLE_SLOTS];
    logic [7:0]  sh_gen;
    logic [7:0]  sh_arena [TEXT_BYTES];
    int unsigned sh_used;
    logic [7:0]  sh_pending [STR_LEN_MAX];
    int unsigned sh_len;
    logic [31:0] sh_hash;
    logic        sh_overlong;
    int unsigned sh_limit;

    sym_item_t item_queue[$];
    lookup_t lookups_due[$];
    int idle_mode;
    int hold_off_cycles;
    int mismatches;
    int cycles;
    int results_seen;
    int items_sent;
    int found_hits;
    int full_hits;
    int long_hits;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void shadow_reset();
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            sh_entry[i] = '0;
            sh_tag[i] = '0;
        end
        sh_gen = 8'd1;
        sh_used = 0;
        sh_limit = 4096;
        sh_len = 0;
        sh_hash = HASH_BASIS;
        sh_overlong = 1'b0;
    endfunction

    function automatic bit text_equal(int unsigned start);
        for (int unsigned i = 0; i < sh_len; i++)
            if (start + i >= TEXT_BYTES || sh_arena[start + i] != sh_pending[i])
                return 1'b0;
        return start + sh_len < TEXT_BYTES && sh_arena[start + sh_len] == 8'd0;
    endfunction

    // Applies one item to the shadow; pushes the expected lookup if one is due.
    function automatic void intern_predict(sym_item_t it);
        lookup_t r;
        int unsigned s;
        int unsigned lim;
        int unsigned room;
        bit have_free;
        r = '0;
        have_free = 1'b0;
        if (it.func == FUNC_CLEAR)
        begin
            sh_used = 0;
            if (sh_gen == GEN_LAST)
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    sh_tag[i] = '0;
                sh_gen = 8'd1;
            end
            else
                sh_gen = sh_gen + 8'd1;
            sh_len = 0;
            sh_hash = HASH_BASIS;
            sh_overlong = 1'b0;
            return;
        end
        if (!it.last)
        begin
            if (it.char_byte == 8'd0)
                return;
            if (sh_len >= STR_LEN_MAX)
                sh_overlong = 1'b1;
            else
            begin
                sh_pending[sh_len] = it.char_byte;
                sh_len++;
                sh_hash = (sh_hash ^ {24'd0, it.char_byte}) * HASH_PRIME;
            end
            return;
        end
        if (sh_overlong)
            r.status = ST_LONG;
        else
        begin
            s = sh_hash & (TABLE_SLOTS - 1);
            for (int n = 0; n < TABLE_SLOTS; n++)
            begin
                if (!(sh_tag[s] == sh_gen && sh_entry[s] != 0))
                begin
                    have_free = 1'b1;
                    break;
                end
                if (text_equal(sh_entry[s] - 1))
                begin
                    r.found = 1'b1;
                    r.offset = 12'(sh_entry[s] - 13'd1);
                    break;
                end
                s = (s + 1) & (TABLE_SLOTS - 1);
            end
            if (!r.found)
            begin
                lim = sh_limit > TEXT_BYTES ? TEXT_BYTES : sh_limit;
                room = sh_used < lim ? lim - sh_used : 0;
                if (!have_free || sh_len + 1 > room)
                    r.status = ST_FULL;
                else
                begin
                    for (int unsigned i = 0; i < sh_len; i++)
                        sh_arena[sh_used + i] = sh_pending[i];
                    sh_arena[sh_used + sh_len] = 8'd0;
                    r.offset = 12'(sh_used);
                    sh_entry[s] = 13'(sh_used + 1);
                    sh_tag[s] = sh_gen;
                    sh_used += sh_len + 1;
                end
            end
        end
        sh_len = 0;
        sh_hash = HASH_BASIS;
        sh_overlong = 1'b0;
        if (r.status != ST_OK)
        begin
            r.found = 1'b0;
            r.offset = '0;
        end
        lookups_due.push_back(r);
    endfunction

    // Driver: holds an item until it is taken, then offers the next one,
    // idling at random by mode.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
        begin
        end
        else if (item_queue.size() > 0 &&
                 !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
                   $urandom_range(99) < ((idle_mode == IDLE_BOTH) ? 9 : 53)))
        begin
            in_valid <= 1'b1;
            {func, char_byte, last} <= item_queue[0];
        end
        else
            in_valid <= 1'b0;
    end

    // Acceptance on the rising edge pops the item and updates the shadow.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            intern_predict(item_queue.pop_front());
            items_sent++;
        end
    end

    // Receiver ready, with random stalls and a long hold-off when the test sets one.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !((idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                           $urandom_range(99) < ((idle_mode == IDLE_BOTH) ? 9 : 53));
    end

    // Monitor: compare each lookup with the oldest expectation.
    always @(posedge clk)
    begin
        lookup_t got;
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{found, offset, status};
            results_seen++;
            if (lookups_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected lookup result f=%0d off=%0d st=%0d",
                             got.found, got.offset, got.status);
            end
            else
            begin
                want = lookups_due.pop_front();
                if (want.found) found_hits++;
                if (want.status == ST_FULL) full_hits++;
                if (want.status == ST_LONG) long_hits++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"lookup mismatch: exp f=%0d off=%0d st=%0d, ",
                                  "got f=%0d off=%0d st=%0d"},
                                 want.found, want.offset, want.status,
                                 got.found, got.offset, got.status);
                end
            end
        end
    end

    task automatic push_string(input string txt);
        for (int i = 0; i < txt.len(); i++)
            item_queue.push_back('{FUNC_STRING, 8'(txt[i]), 1'b0});
        item_queue.push_back('{FUNC_STRING, 8'd0, 1'b0 | 1'b1});
    endtask

    task automatic push_bytes(input int n, input int alphabet);
        for (int i = 0; i < n; i++)
            item_queue.push_back('{FUNC_STRING, 8'($urandom_range(alphabet, 1)), 1'b0});
        item_queue.push_back('{FUNC_STRING, 8'($urandom_range(255)), 1'b1});
    endtask

    task automatic push_clear();
        item_queue.push_back('{FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1))});
    endtask

    // Waits for the queue to drain and every result to arrive, then some slack.
    task automatic drain();
        while (item_queue.size() > 0 || lookups_due.size() > 0 || in_valid)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic set_limit(input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 13'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        sh_limit = value;
    endtask

    // Random mix: mostly well-formed strings from a small pool so repeats hit.
    task automatic random_phase(input int n_items);
        int sent;
        int r;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                push_clear();
                sent++;
            end
            else if (r < 6)
            begin
                item_queue.push_back('{FUNC_STRING, 8'd0, 1'b0});
                push_bytes(1, 255);
                sent += 2;
            end
            else
            begin
                len = (r < 20) ? $urandom_range(20) : $urandom_range(3);
                push_bytes(len, (r < 60) ? 3 : 255);
                sent += len + 1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = 1'b0;
        char_byte = 8'd0;
        last = 1'b0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 13'd0;
        idle_mode = IDLE_NONE;
        hold_off_cycles = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        found_hits = 0;
        full_hits = 0;
        long_hits = 0;
        shadow_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty string, repeats, zero byte, extremes, overlong, clear.
        push_string("");
        push_string("");
        push_string("a");
        push_string("a");
        item_queue.push_back('{FUNC_STRING, 8'd0, 1'b0});
        item_queue.push_back('{FUNC_STRING, 8'hFF, 1'b0});
        item_queue.push_back('{FUNC_STRING, 8'h01, 1'b1});
        push_string("ab");
        item_queue.push_back('{FUNC_STRING, 8'h55, 1'b0});
        item_queue.push_back('{FUNC_CLEAR, 8'hAA, 1'b1});
        push_string("a");
        push_bytes(STR_LEN_MAX + 1, 255);
        drain();

        // Tiny arena forces the full case, then zero and oversize limits.
        set_limit(5);
        push_clear();
        push_string("abc");
        push_string("de");
        push_string("abc");
        drain();
        set_limit(0);
        push_string("");
        drain();
        set_limit(8191);
        push_clear();

        // Walk the generation around its wrap with cheap clears.
        for (int i = 0; i < 255; i++)
            push_clear();
        push_string("q");
        push_string("q");
        drain();

        idle_mode = IDLE_NONE;
        random_phase(50);
        drain();
        idle_mode = IDLE_SEND;
        random_phase(50);
        drain();
        set_limit(60);
        idle_mode = IDLE_RECV;
        random_phase(50);
        drain();
        set_limit(4096);
        idle_mode = IDLE_BOTH;
        random_phase(40);
        // Long receiver hold-off while the sender keeps offering.
        hold_off_cycles = 2000;
        drain();

        $display("covered %0d items, %0d lookups: %0d hits, %0d full, %0d overlong",
                 items_sent, results_seen, found_hits, full_hits, long_hits);
        if (mismatches == 0)
            $display("end of test: clean");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
